@@ src/lsmb_pkg.sv @@
`default_nettype none

package lsmb_pkg;

    // field widths
    localparam int LUX_W   = 32;
    localparam int OFF_W   = 15;
    localparam int MAG_W   = 16;
    localparam int HALF_W  = 5;
    localparam int ROM_W   = 17;
    localparam int FRAC_W  = 16;
    localparam int LOG_W   = 22;
    localparam int CTERM_W = 26;
    localparam int MAG20_W = 28;
    localparam int CFG_AW  = 1;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_OFFSET  = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_MIN_LUX = 1'b1;

    // magnitude constants, Q20
    localparam logic signed [MAG20_W-1:0] MAG_K_Q20 = 28'sd22664403;
    localparam logic [19:0]               MAG_C_Q20 = 20'd789132;

    // half-bortle thresholds, Q10, brightest rung last
    localparam int LADDER_N = 16;
    localparam logic [MAG_W-1:0] LADDER_Q10 [LADDER_N] = '{
        16'd22522, 16'd22517, 16'd22466, 16'd22415, 16'd22312, 16'd22210,
        16'd21760, 16'd20981, 16'd20480, 16'd19968, 16'd19681, 16'd19394,
        16'd19107, 16'd18821, 16'd18595, 16'd18370
    };
    localparam logic [HALF_W-1:0] HALF_DARKEST  = 5'd2;
    localparam logic [HALF_W-1:0] HALF_BRIGHTEST = 5'd18;

    // leading-one position and normalised fraction
    typedef struct packed {
        logic [4:0]       e;
        logic [LUX_W-1:0] f;
    } t_lod;

endpackage

`default_nettype wire

@@ src/lsmb_lod.sv @@
`default_nettype none

module lsmb_lod (
    input  wire logic [lsmb_pkg::LUX_W-1:0] i_value,
    output lsmb_pkg::t_lod                  o_lod
);

    logic [4:0]                   n_pos;
    logic [lsmb_pkg::LUX_W-1:0]   n_shifted;

    // priority encoder, highest set bit wins
    always_comb begin
        n_pos = 5'd0;
        for (int i = 0; i < lsmb_pkg::LUX_W; i++) begin
            if (i_value[i]) begin
                n_pos = 5'(i);
            end
        end
    end

    // move the leading one to the top and drop it
    assign n_shifted = i_value << (5'd31 - n_pos);
    assign o_lod.e   = n_pos;
    assign o_lod.f   = {n_shifted[lsmb_pkg::LUX_W-2:0], 1'b0};

endmodule

`default_nettype wire

@@ src/lsmb_log_rom.sv @@
`default_nettype none

module lsmb_log_rom #(
    parameter int LOG_TABLE_ENTRIES = 64
) (
    input  wire logic [$clog2(LOG_TABLE_ENTRIES)-1:0] i_idx,
    output logic [lsmb_pkg::ROM_W-1:0]                o_lo,
    output logic [lsmb_pkg::ROM_W-1:0]                o_diff
);

    localparam int RomAw = $clog2(LOG_TABLE_ENTRIES + 1);

    // fraction bits of log2(1 + i/n) by repeated squaring in Q2.30
    function automatic logic [lsmb_pkg::ROM_W-1:0] rom_entry(input int unsigned i);
        logic [63:0] x;
        logic [15:0] acc;
        x   = (64'd1 << 30) + ((64'(i) << 30) / 64'(LOG_TABLE_ENTRIES));
        acc = 16'd0;
        for (int b = 0; b < 16; b++) begin
            x   = (x * x) >> 30;
            acc = {acc[14:0], 1'b0};
            if (x >= (64'd2 << 30)) begin
                acc[0] = 1'b1;
                x      = x >> 1;
            end
        end
        if (i == LOG_TABLE_ENTRIES) begin
            rom_entry = 17'h10000;
        end else begin
            rom_entry = {1'b0, acc};
        end
    endfunction

    logic [lsmb_pkg::ROM_W-1:0] w_rom [LOG_TABLE_ENTRIES+1];
    logic [RomAw-1:0]           n_lo_addr;
    logic [RomAw-1:0]           n_hi_addr;
    logic [lsmb_pkg::ROM_W-1:0] n_hi;

    // constant table, one entry past the end for the upper segment point
    for (genvar g = 0; g <= LOG_TABLE_ENTRIES; g++) begin : g_rom
        assign w_rom[g] = rom_entry(g);
    end

    assign n_lo_addr = RomAw'(i_idx);
    assign n_hi_addr = n_lo_addr + RomAw'(1);
    assign o_lo      = w_rom[n_lo_addr];
    assign n_hi      = w_rom[n_hi_addr];
    assign o_diff    = n_hi - o_lo;

endmodule

`default_nettype wire

@@ src/lsmb_mag_calc.sv @@
`default_nettype none

module lsmb_mag_calc (
    input  wire logic [lsmb_pkg::CTERM_W-1:0]     i_cterm,
    input  wire logic signed [lsmb_pkg::OFF_W-1:0] i_offset,
    output logic [lsmb_pkg::MAG_W-1:0]             o_mag
);

    logic signed [lsmb_pkg::MAG20_W-1:0] n_off;
    logic signed [lsmb_pkg::MAG20_W-1:0] n_mag20;
    logic [lsmb_pkg::MAG20_W-2:0]        n_rnd;
    logic [lsmb_pkg::MAG_W:0]            n_q10;

    // offset in Q20, sign extended
    assign n_off   = {{3{i_offset[lsmb_pkg::OFF_W-1]}}, i_offset, 10'b0};
    assign n_mag20 = lsmb_pkg::MAG_K_Q20 - $signed({2'b00, i_cterm}) + n_off;

    // round to Q10
    assign n_rnd = n_mag20[lsmb_pkg::MAG20_W-2:0] + 27'd512;
    assign n_q10 = n_rnd[lsmb_pkg::MAG20_W-2:10];

    // clamp at zero, saturate at the top of the range
    always_comb begin
        priority if (n_mag20[lsmb_pkg::MAG20_W-1]) begin
            o_mag = '0;
        end else if (n_q10[lsmb_pkg::MAG_W]) begin
            o_mag = '1;
        end else begin
            o_mag = n_q10[lsmb_pkg::MAG_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ src/lsmb_bortle.sv @@
`default_nettype none

module lsmb_bortle (
    input  wire logic [lsmb_pkg::MAG_W-1:0] i_mag,
    output logic [lsmb_pkg::HALF_W-1:0]     o_half
);

    // first rung the magnitude clears, darkest rung first
    always_comb begin
        o_half = lsmb_pkg::HALF_BRIGHTEST;
        for (int k = lsmb_pkg::LADDER_N - 1; k >= 0; k--) begin
            if (i_mag > lsmb_pkg::LADDER_Q10[k]) begin
                o_half = lsmb_pkg::HALF_DARKEST + 5'(k);
            end
        end
    end

endmodule

`default_nettype wire

@@ src/lux_to_sky_magnitude_and_bortle.sv @@
// channel   dir  bits   contents
// s_axis    in   tdata  [31:0] lux_average
//                tuser  [0] average_ready
// m_axis    out  tdata  [15:0] sky_magnitude, [20:16] bortle_half_steps, rest zero
//                tuser  [0] magnitude_valid, [1] bortle_valid
// cfg       in   i_cfg_we, i_cfg_addr (0 offset, 1 min lux), i_cfg_data
//
// one request per cycle sustained while the output is not stalled
// seven register stages: input, leading-one detect, segment multiply, table read,
// interpolation, scale multiply, magnitude and ladder into the output register
// every stage holds its own valid bit, so bubbles fill while the output is stalled
// reset (synchronous, active low) empties the pipe and clears both registers
`default_nettype none

module lux_to_sky_magnitude_and_bortle #(
    parameter int LOG_TABLE_ENTRIES = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] lux_average
    input  wire logic [0:0]  s_axis_tuser,   // [0] average_ready
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [15:0] sky_magnitude, [20:16] bortle_half_steps
    output logic [1:0]       m_axis_tuser,   // [0] magnitude_valid, [1] bortle_valid
    input  wire logic        i_cfg_we,
    input  wire logic [lsmb_pkg::CFG_AW-1:0] i_cfg_addr,
    input  wire logic [31:0] i_cfg_data
);

    localparam int IdxW   = $clog2(LOG_TABLE_ENTRIES);
    localparam int NW     = $clog2(LOG_TABLE_ENTRIES + 1);
    localparam int SW     = lsmb_pkg::LUX_W + NW;
    localparam int NStage = 7;

    // configuration
    logic signed [lsmb_pkg::OFF_W-1:0] r_offset;
    logic [lsmb_pkg::LUX_W-1:0]        r_min_lux;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset  <= '0;
            r_min_lux <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                lsmb_pkg::CFG_OFFSET:  r_offset  <= i_cfg_data[lsmb_pkg::OFF_W-1:0];
                lsmb_pkg::CFG_MIN_LUX: r_min_lux <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // per-stage flow control
    logic [NStage-1:0] r_vld;
    logic [NStage-1:0] n_en;

    always_comb begin
        n_en[NStage-1] = !r_vld[NStage-1] || m_axis_tready;
        for (int k = NStage - 2; k >= 0; k--) begin
            n_en[k] = !r_vld[k] || n_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NStage; k++) begin
                if (n_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign s_axis_tready = n_en[0];

    // stage 0: input register
    logic [lsmb_pkg::LUX_W-1:0] r_lux;
    logic                       r_rdy;

    always_ff @(posedge i_clk) begin
        if (n_en[0]) begin
            r_lux <= s_axis_tdata;
            r_rdy <= s_axis_tuser[0];
        end
    end

    // stage 1: validity and leading-one detect
    lsmb_pkg::t_lod             n_lod;
    logic                       r1_ok;
    logic [4:0]                 r1_e;
    logic [lsmb_pkg::LUX_W-1:0] r1_f;

    lsmb_lod u_lod (
        .i_value (r_lux),
        .o_lod   (n_lod)
    );

    always_ff @(posedge i_clk) begin
        if (n_en[1]) begin
            r1_ok <= r_rdy && (r_lux > r_min_lux);
            r1_e  <= n_lod.e;
            r1_f  <= n_lod.f;
        end
    end

    // stage 2: fraction times segment count
    logic [SW-1:0]                 n_s;
    logic                          r2_ok;
    logic [4:0]                    r2_e;
    logic [lsmb_pkg::LUX_W+IdxW-1:0] r2_s;

    assign n_s = SW'(r1_f) * SW'(LOG_TABLE_ENTRIES);

    always_ff @(posedge i_clk) begin
        if (n_en[2]) begin
            r2_ok <= r1_ok;
            r2_e  <= r1_e;
            r2_s  <= n_s[lsmb_pkg::LUX_W+IdxW-1:0];
        end
    end

    // stage 3: table read
    logic [lsmb_pkg::ROM_W-1:0]  n_lo;
    logic [lsmb_pkg::ROM_W-1:0]  n_diff;
    logic                        r3_ok;
    logic [4:0]                  r3_e;
    logic [lsmb_pkg::ROM_W-1:0]  r3_lo;
    logic [lsmb_pkg::ROM_W-1:0]  r3_diff;
    logic [lsmb_pkg::FRAC_W-1:0] r3_w;

    lsmb_log_rom #(
        .LOG_TABLE_ENTRIES (LOG_TABLE_ENTRIES)
    ) u_rom (
        .i_idx  (r2_s[lsmb_pkg::LUX_W+IdxW-1:lsmb_pkg::LUX_W]),
        .o_lo   (n_lo),
        .o_diff (n_diff)
    );

    always_ff @(posedge i_clk) begin
        if (n_en[3]) begin
            r3_ok   <= r2_ok;
            r3_e    <= r2_e;
            r3_lo   <= n_lo;
            r3_diff <= n_diff;
            r3_w    <= r2_s[31:16];
        end
    end

    // stage 4: linear interpolation into log2, Q16
    logic [lsmb_pkg::ROM_W+lsmb_pkg::FRAC_W-1:0] n_iprod;
    logic [lsmb_pkg::LOG_W-1:0]                  n_log;
    logic                                        r4_ok;
    logic [lsmb_pkg::LOG_W-1:0]                  r4_log;

    assign n_iprod = 33'(r3_diff) * 33'(r3_w);
    assign n_log   = lsmb_pkg::LOG_W'({r3_e, 16'b0}) + lsmb_pkg::LOG_W'(r3_lo)
                   + lsmb_pkg::LOG_W'(n_iprod[32:16]);

    always_ff @(posedge i_clk) begin
        if (n_en[4]) begin
            r4_ok  <= r3_ok;
            r4_log <= n_log;
        end
    end

    // stage 5: scale by 2.5*log10(2)
    logic [41:0]                  n_cprod;
    logic                         r5_ok;
    logic [lsmb_pkg::CTERM_W-1:0] r5_t;

    assign n_cprod = 42'(r4_log) * 42'(lsmb_pkg::MAG_C_Q20);

    always_ff @(posedge i_clk) begin
        if (n_en[5]) begin
            r5_ok <= r4_ok;
            r5_t  <= n_cprod[41:16];
        end
    end

    // stage 6: magnitude, ladder and output register
    logic [lsmb_pkg::MAG_W-1:0]  n_mag;
    logic [lsmb_pkg::HALF_W-1:0] n_half;
    logic [lsmb_pkg::MAG_W-1:0]  r6_mag;
    logic [lsmb_pkg::HALF_W-1:0] r6_half;
    logic                        r6_ok;

    lsmb_mag_calc u_mag (
        .i_cterm  (r5_t),
        .i_offset (r_offset),
        .o_mag    (n_mag)
    );

    lsmb_bortle u_bortle (
        .i_mag  (n_mag),
        .o_half (n_half)
    );

    always_ff @(posedge i_clk) begin
        if (n_en[6]) begin
            r6_ok   <= r5_ok;
            r6_mag  <= r5_ok ? n_mag : '0;
            r6_half <= r5_ok ? n_half : '0;
        end
    end

    assign m_axis_tvalid = r_vld[NStage-1];
    assign m_axis_tdata  = {3'b000, r6_half, r6_mag};
    assign m_axis_tuser  = {r6_ok, r6_ok};

endmodule

`default_nettype wire

@@ src/lsmb_checker.sv @@
`default_nettype none

module lsmb_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    // stalled result holds still
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result shown straight after reset");

    // invalid results carry all-zero fields, both flags agree
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            m_axis_tdata == 24'd0 && !m_axis_tuser[1])
        else $error("invalid result with non-zero fields");

    // valid class lies on the ladder
    a_half_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tuser[1] && m_axis_tdata[20:16] >= 5'd2 && m_axis_tdata[20:16] <= 5'd18)
        else $error("bortle class out of range");

    // darkest skies map to the top rung
    a_dark_rung: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] && m_axis_tdata[15:0] > 16'd22522 |->
            m_axis_tdata[20:16] == 5'd2)
        else $error("dark sky not on the top rung");

endmodule

bind lux_to_sky_magnitude_and_bortle lsmb_checker u_lsmb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ sim/tb_lux_to_sky_magnitude_and_bortle.sv @@
`timescale 1ns / 100ps

module tb_lux_to_sky_magnitude_and_bortle;

    // predictor constants
    localparam int          LOG_SEGS = 64;
    localparam longint      MAG_K    = 64'sd22664403;
    localparam longint      MAG_C    = 64'sd789132;
    localparam int unsigned RUNG_Q10 [16] = '{
        22522, 22517, 22466, 22415, 22312, 22210, 21760, 20981,
        20480, 19968, 19681, 19394, 19107, 18821, 18595, 18370
    };

    // one output request, split into its fields
    typedef struct packed {
        logic [15:0] mag;
        logic [4:0]  half;
        logic        mag_ok;
        logic        half_ok;
    } t_sky_result;

    // directed stimulus rows; addr is ignored on item rows
    typedef enum logic { ROW_ITEM, ROW_CFG } t_row_kind;

    typedef struct packed {
        t_row_kind                   kind;
        logic [lsmb_pkg::CFG_AW-1:0] addr;
        logic [31:0]                 word;
        logic                        rdy;
        logic                        typed;
        logic [15:0]                 mag;
        logic [4:0]                  half;
        logic                        ok;
    } t_dir_row;

    localparam int DIR_ROWS = 25;
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        // not ready and zero lux give an all-zero request
        '{ROW_ITEM, lsmb_pkg::CFG_OFFSET,  32'h0000_0000, 1'b1, 1'b1, 16'd0, 5'd0,  1'b0},
        '{ROW_ITEM, lsmb_pkg::CFG_OFFSET,  32'h0000_1000, 1'b0, 1'b1, 16'd0, 5'd0,  1'b0},
        '{ROW_ITEM, lsmb_pkg::CFG_OFFSET,  32'hFFFF_FFFF, 1'b0, 1'b1, 16'd0, 5'd0,  1'b0},
        // brightest input clamps at zero magnitude
        '{ROW_ITEM, lsmb_pkg::CFG_OFFSET,  32'hFFFF_FFFF, 1'b1, 1'b1, 16'd0, 5'd18, 1'b1},
        '{ROW_ITEM, lsmb_pkg::CFG_OFFSET,  32'h0000_0001, 1'b1, 1'b0, 16'd0, 5'd0,  1'b0},
        '{ROW_ITEM, lsmb_pkg::CFG_OFFSET,  32'h0000_1000, 1'b1, 1'b0, 16'd0, 5'd0,  1'b0},
        '{ROW_ITEM, lsmb_pkg::CFG_OFFSET,  32'h8000_0000, 1'b1, 1'b0, 16'd0, 5'd0,  1'b0},
        '{ROW_ITEM, lsmb_pkg::CFG_OFFSET,  32'h7FFF_FFFF, 1'b1, 1'b0, 16'd0, 5'd0,  1'b0},
        '{ROW_ITEM, lsmb_pkg::CFG_OFFSET,  32'h0000_0003, 1'b1, 1'b0, 16'd0, 5'd0,  1'b0},
        '{ROW_ITEM, lsmb_pkg::CFG_OFFSET,  32'h1234_5678, 1'b1, 1'b0, 16'd0, 5'd0,  1'b0},
        '{ROW_ITEM, lsmb_pkg::CFG_OFFSET,  32'h0000_0018, 1'b1, 1'b0, 16'd0, 5'd0,  1'b0},
        // threshold: at min lux is dark, one above is valid
        '{ROW_CFG,  lsmb_pkg::CFG_MIN_LUX, 32'h0000_1000, 1'b0, 1'b0, 16'd0, 5'd0,  1'b0},
        '{ROW_ITEM, lsmb_pkg::CFG_OFFSET,  32'h0000_1000, 1'b1, 1'b1, 16'd0, 5'd0,  1'b0},
        '{ROW_ITEM, lsmb_pkg::CFG_OFFSET,  32'h0000_1001, 1'b1, 1'b0, 16'd0, 5'd0,  1'b0},
        '{ROW_ITEM, lsmb_pkg::CFG_OFFSET,  32'h0000_0FFF, 1'b1, 1'b1, 16'd0, 5'd0,  1'b0},
        '{ROW_CFG,  lsmb_pkg::CFG_MIN_LUX, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'd0, 5'd0,  1'b0},
        '{ROW_ITEM, lsmb_pkg::CFG_OFFSET,  32'hFFFF_FFFF, 1'b1, 1'b1, 16'd0, 5'd0,  1'b0},
        '{ROW_CFG,  lsmb_pkg::CFG_MIN_LUX, 32'h0000_0000, 1'b0, 1'b0, 16'd0, 5'd0,  1'b0},
        // largest offset, upper data bits set and ignored
        '{ROW_CFG,  lsmb_pkg::CFG_OFFSET,  32'hFFFF_BFFF, 1'b0, 1'b0, 16'd0, 5'd0,  1'b0},
        '{ROW_ITEM, lsmb_pkg::CFG_OFFSET,  32'h0000_0001, 1'b1, 1'b0, 16'd0, 5'd0,  1'b0},
        '{ROW_ITEM, lsmb_pkg::CFG_OFFSET,  32'hFFFF_FFFF, 1'b1, 1'b0, 16'd0, 5'd0,  1'b0},
        // most negative offset
        '{ROW_CFG,  lsmb_pkg::CFG_OFFSET,  32'h0000_4000, 1'b0, 1'b0, 16'd0, 5'd0,  1'b0},
        '{ROW_ITEM, lsmb_pkg::CFG_OFFSET,  32'h0000_0001, 1'b1, 1'b0, 16'd0, 5'd0,  1'b0},
        '{ROW_ITEM, lsmb_pkg::CFG_OFFSET,  32'hFFFF_FFFF, 1'b1, 1'b1, 16'd0, 5'd18, 1'b1},
        '{ROW_CFG,  lsmb_pkg::CFG_OFFSET,  32'h0000_0000, 1'b0, 1'b0, 16'd0, 5'd0,  1'b0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;    // [31:0] lux_average
    logic [0:0]  s_axis_tuser;    // [0] average_ready
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;    // [15:0] sky_magnitude, [20:16] bortle_half_steps
    logic [1:0]  m_axis_tuser;    // [0] magnitude_valid, [1] bortle_valid
    logic        i_cfg_we;
    logic [lsmb_pkg::CFG_AW-1:0] i_cfg_addr;
    logic [31:0] i_cfg_data;

    // shadow of the block's registers and the mantissa log table
    logic signed [14:0] cal_offset;
    logic [31:0]        min_lux_q;
    longint unsigned    log_frac_rom [LOG_SEGS+1];

    t_sky_result pending_sky [$];
    int          mismatch_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int unsigned holds_asked;

    lux_to_sky_magnitude_and_bortle dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #10ms;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("mismatch %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // log2(1+i/N) in 16 fraction bits by repeated squaring
    function automatic void build_log_frac_rom();
        longint unsigned x;
        longint unsigned acc;
        for (int i = 0; i < LOG_SEGS; i++) begin
            x   = (64'd1 << 30) + ((longint'(i) << 30) / LOG_SEGS);
            acc = 0;
            for (int b = 0; b < 16; b++) begin
                x   = (x * x) >> 30;
                acc = acc << 1;
                if (x >= (64'd2 << 30)) begin
                    acc = acc | 1;
                    x   = x >> 1;
                end
            end
            log_frac_rom[i] = acc;
        end
        log_frac_rom[LOG_SEGS] = 65536;
    endfunction

    // expected magnitude and half-bortle step for one lux request
    function automatic t_sky_result predict_sky(input logic [31:0] lux, input logic rdy);
        t_sky_result     r;
        int              e;
        longint unsigned frac, seg, idx, w, lo, hi, lg, mag10;
        longint          mag20;
        logic            hit;
        r = '0;
        if (!rdy || lux <= min_lux_q)
            return r;
        // leading one and fraction behind it
        e = 31;
        while (e > 0 && !lux[e])
            e--;
        frac = ({32'd0, lux} << (32 - e)) & 64'hFFFF_FFFF;
        seg  = frac * LOG_SEGS;
        idx  = seg >> 32;
        if (idx >= LOG_SEGS)
            idx = LOG_SEGS - 1;
        w  = (seg >> 16) & 64'hFFFF;
        lo = log_frac_rom[idx];
        hi = log_frac_rom[idx + 1];
        lg = (longint'(e) << 16) + lo + (((hi - lo) * w) >> 16);
        // magnitude in Q20, then rounded to Q10 with clamp and saturation
        mag20 = MAG_K - longint'((lg * MAG_C) >> 16) + longint'(cal_offset) * 1024;
        if (mag20 < 0)
            mag10 = 0;
        else begin
            mag10 = (longint'(mag20) + 512) >> 10;
            if (mag10 > 65535)
                mag10 = 65535;
        end
        // half-bortle ladder, darkest rung first
        r.half = 5'd18;
        hit    = 1'b0;
        for (int k = 0; k < 16; k++) begin
            if (!hit && mag10 > RUNG_Q10[k]) begin
                r.half = 5'(2 + k);
                hit    = 1'b1;
            end
        end
        r.mag     = mag10[15:0];
        r.mag_ok  = 1'b1;
        r.half_ok = 1'b1;
        return r;
    endfunction

    // offer one lux request, record what it should give once accepted
    task automatic offer_lux(input logic [31:0] lux, input logic rdy, input logic typed,
                             input t_sky_result typed_res);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = lux;
        s_axis_tuser  = rdy;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        pending_sky.push_back(typed ? typed_res : predict_sky(lux, rdy));
        @(negedge i_clk);
    endtask

    // register write once the pipe has drained
    task automatic write_reg(input logic [lsmb_pkg::CFG_AW-1:0] addr, input logic [31:0] data);
        s_axis_tvalid = 1'b0;
        wait (pending_sky.size() == 0);
        repeat (10) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_addr = addr;
        i_cfg_data = data;
        if (addr == lsmb_pkg::CFG_OFFSET)
            cal_offset = data[14:0];
        else
            min_lux_q = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // output side: random stalls plus a long hold-off on request
    initial begin : receiver
        int unsigned holds_seen;
        int          hold_left;
        holds_seen    = 0;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_seen != holds_asked) begin
                holds_seen = holds_asked;
                hold_left  = 80;
            end
            if (hold_left > 0) begin
                m_axis_tready = 1'b0;
                hold_left--;
            end else
                m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin : check_result
        t_sky_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_sky.size() == 0)
                report_mismatch("result with nothing pending", m_axis_tdata, 0);
            else begin
                want = pending_sky.pop_front();
                if (m_axis_tdata[15:0] !== want.mag)
                    report_mismatch("sky_magnitude", m_axis_tdata[15:0], want.mag);
                if (m_axis_tdata[20:16] !== want.half)
                    report_mismatch("bortle_half_steps", m_axis_tdata[20:16], want.half);
                if (m_axis_tdata[23:21] !== 3'd0)
                    report_mismatch("tdata padding", m_axis_tdata[23:21], 0);
                if (m_axis_tuser[0] !== want.mag_ok)
                    report_mismatch("magnitude_valid", m_axis_tuser[0], want.mag_ok);
                if (m_axis_tuser[1] !== want.half_ok)
                    report_mismatch("bortle_valid", m_axis_tuser[1], want.half_ok);
            end
        end
    end

    // stimulus
    initial begin : stimulus
        logic [31:0] lux;
        logic [31:0] data;
        logic        rdy;
        t_sky_result typed_res;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        i_cfg_we       = 1'b0;
        i_cfg_addr     = lsmb_pkg::CFG_OFFSET;
        i_cfg_data     = '0;
        cal_offset     = '0;
        min_lux_q      = '0;
        mismatch_count = 0;
        send_idle_pct  = 27;
        recv_idle_pct  = 67;
        holds_asked    = 0;
        build_log_frac_rom();
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed table
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (DIR_TABLE[i].kind == ROW_CFG)
                write_reg(DIR_TABLE[i].addr, DIR_TABLE[i].word);
            else begin
                typed_res = '{mag: DIR_TABLE[i].mag, half: DIR_TABLE[i].half,
                              mag_ok: DIR_TABLE[i].ok, half_ok: DIR_TABLE[i].ok};
                offer_lux(DIR_TABLE[i].word, DIR_TABLE[i].rdy, DIR_TABLE[i].typed, typed_res);
            end
        end

        // random part: three idling modes, four register settings each
        typed_res = '0;
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 27 : (mode == 1) ? 67 : 0;
            recv_idle_pct = (mode == 0) ? 67 : (mode == 1) ? 27 : 0;
            for (int phase = 0; phase < 4; phase++) begin
                data = $urandom;
                case ($urandom_range(3))
                    0:       data[14:0] = 15'h3FFF;
                    1:       data[14:0] = 15'h4000;
                    default: data[14:0] = 15'($urandom_range(6144) - 3072);
                endcase
                write_reg(lsmb_pkg::CFG_OFFSET, data);
                case ($urandom_range(3))
                    0:       data = 32'd0;
                    1:       data = $urandom;
                    default: data = $urandom >> $urandom_range(4, 31);
                endcase
                write_reg(lsmb_pkg::CFG_MIN_LUX, data);
                for (int n = 0; n < 145; n++) begin
                    // long output stall while the input keeps coming
                    if (mode == 2 && phase == 1 && n == 20)
                        holds_asked++;
                    // input pause until the pipe is empty
                    if (mode == 2 && phase == 2 && n == 100) begin
                        s_axis_tvalid = 1'b0;
                        wait (pending_sky.size() == 0);
                        repeat ($urandom_range(3, 12)) @(negedge i_clk);
                    end
                    case ($urandom_range(3))
                        0:       lux = $urandom_range(1, 64);
                        1:       lux = min_lux_q + $urandom_range(3);
                        default: lux = $urandom >> $urandom_range(31);
                    endcase
                    rdy = ($urandom_range(9) != 0);
                    offer_lux(lux, rdy, 1'b0, typed_res);
                end
            end
        end

        // drain and finish
        s_axis_tvalid = 1'b0;
        wait (pending_sky.size() == 0);
        repeat (12) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
src/lsmb_pkg.sv
src/lsmb_lod.sv
src/lsmb_log_rom.sv
src/lsmb_mag_calc.sv
src/lsmb_bortle.sv
src/lux_to_sky_magnitude_and_bortle.sv
src/lsmb_checker.sv
sim/tb_lux_to_sky_magnitude_and_bortle.sv
